@@ src/nca_pkg.sv @@
// shared types, codes and helpers for the note channel allocator
// no dependencies
package nca_pkg;

    localparam int ROW_W = 12;
    localparam int CH_OUT_W = 3;
    localparam int ST_W = 3;
    localparam int MAX_CH = 32;
    localparam int MAX_DEPTH = 4096;

    localparam logic CMD_PLACE = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    localparam logic [ST_W-1:0] ST_FREE = 3'd0;
    localparam logic [ST_W-1:0] ST_STOLEN = 3'd1;
    localparam logic [ST_W-1:0] ST_TRUNC = 3'd2;
    localparam logic [ST_W-1:0] ST_DROP = 3'd3;
    localparam logic [ST_W-1:0] ST_CLEAR = 3'd4;

    typedef struct packed {
        logic load;
        logic clear_run;
        logic scan_run;
        logic decide;
        logic write_run;
        logic out_load;
    } t_nca_cmd;

    typedef struct packed {
        logic clear_done;
        logic scan_done;
        logic write_done;
        logic bad;
        logic fail;
        logic is_clear;
    } t_nca_stat;

    // index of lowest set bit, zero when none
    function automatic logic [4:0] f_lowest(input logic [MAX_CH-1:0] m);
        logic [4:0] idx;
        idx = '0;
        for (int i = MAX_CH - 1; i >= 0; i--) begin
            if (m[i]) begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ src/note_channel_allocator.sv @@
// note channel allocator: places note events onto output channels with stealing
// depends on nca_pkg, nca_ctrl, nca_dp
// a place transfer scans its rows, chooses a channel, then writes the rows back
// a clear transfer writes every map row, one map row written per cycle
// one item is in work at a time; the single memory read port walks the rows twice
// after reset a clearing pass over all min(ROWS, 4096) map rows runs with input stalled
module note_channel_allocator #(
    parameter int CHANNELS = 8,
    parameter int ROWS = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_command,
    input  logic [nca_pkg::ROW_W-1:0]      i_start_row,
    input  logic [nca_pkg::ROW_W-1:0]      i_end_row,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [nca_pkg::CH_OUT_W-1:0]   o_channel,
    output logic [nca_pkg::ROW_W-1:0]      o_placed_end_row,
    output logic [nca_pkg::ST_W-1:0]       o_status
);
    import nca_pkg::*;

    t_nca_cmd  cmd;
    t_nca_stat stat;

    nca_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    nca_dp #(
        .CHANNELS (CHANNELS),
        .ROWS     (ROWS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_command        (i_command),
        .i_start_row      (i_start_row),
        .i_end_row        (i_end_row),
        .o_channel        (o_channel),
        .o_placed_end_row (o_placed_end_row),
        .o_status         (o_status)
    );

endmodule

@@ src/nca_dp.sv @@
// datapath: row map memory, scan accumulators, channel choice, result registers
// depends on nca_pkg
module nca_dp #(
    parameter int CHANNELS = 8,
    parameter int ROWS = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  nca_pkg::t_nca_cmd              i_cmd,
    output nca_pkg::t_nca_stat             o_stat,
    input  logic                           i_command,
    input  logic [nca_pkg::ROW_W-1:0]      i_start_row,
    input  logic [nca_pkg::ROW_W-1:0]      i_end_row,
    output logic [nca_pkg::CH_OUT_W-1:0]   o_channel,
    output logic [nca_pkg::ROW_W-1:0]      o_placed_end_row,
    output logic [nca_pkg::ST_W-1:0]       o_status
);
    import nca_pkg::*;

    localparam int DEPTH = (ROWS < MAX_DEPTH) ? ROWS : MAX_DEPTH;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CHANNELS-1:0] ALL = '1;

    // occupancy in the low half, attack in the high half
    logic [2*CHANNELS-1:0] mem [DEPTH];

    logic                  r_cmd;
    logic                  r_bad;
    logic                  r_fail;
    logic [AW-1:0]         r_s;
    logic [AW-1:0]         r_lim;
    logic [AW-1:0]         r_ptr;
    logic                  r_issue_done;
    logic                  r_rv;
    logic [AW-1:0]         r_drow;
    logic [2*CHANNELS-1:0] r_rdata;
    logic [CHANNELS-1:0]   r_occ;
    logic [CHANNELS-1:0]   r_att;
    logic [CHANNELS-1:0]   r_alive;
    logic [CHANNELS-1:0]   r_tmask;
    logic [AW-1:0]         r_tlast;
    logic [CW-1:0]         r_ch;
    logic [ST_W-1:0]       r_st;
    logic [CH_OUT_W-1:0]   r_o_ch;
    logic [ROW_W-1:0]      r_o_end;
    logic [ST_W-1:0]       r_o_st;

    logic                  rd_en;
    logic                  wr_en;
    logic [AW-1:0]         waddr;
    logic [2*CHANNELS-1:0] wdata;
    logic [CHANNELS-1:0]   rocc;
    logic [CHANNELS-1:0]   ratt;
    logic [CHANNELS-1:0]   nalive;
    logic [CHANNELS-1:0]   free_m;
    logic [CHANNELS-1:0]   steal_m;
    logic [CHANNELS-1:0]   bit_m;
    logic                  in_bad;
    logic [4:0]            ch5;

    assign rocc = r_rdata[CHANNELS-1:0];
    assign ratt = r_rdata[2*CHANNELS-1:CHANNELS];
    assign nalive = r_alive & ~ratt;
    assign free_m = ALL & ~r_occ;
    assign steal_m = ALL & ~r_att;
    assign bit_m = CHANNELS'(1) << r_ch;
    assign in_bad = (i_end_row < i_start_row) || (32'(i_end_row) >= 32'(ROWS));
    assign ch5 = 5'(r_ch);

    assign rd_en = (i_cmd.scan_run || i_cmd.write_run) && !r_issue_done;
    assign wr_en = i_cmd.clear_run || (i_cmd.write_run && r_rv);
    assign waddr = i_cmd.clear_run ? r_ptr : r_drow;

    always_comb begin
        wdata = '0;
        if (!i_cmd.clear_run) begin
            wdata[CHANNELS-1:0] = rocc | bit_m;
            wdata[2*CHANNELS-1:CHANNELS] = (r_drow == r_s) ? (ratt | bit_m) : (ratt & ~bit_m);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[waddr] <= wdata;
        end
        if (rd_en) begin
            r_rdata <= mem[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
            r_issue_done <= 1'b1;
            r_rv <= 1'b0;
        end else begin
            r_rv <= rd_en;
            if (rd_en) begin
                r_drow <= r_ptr;
            end
            if (i_cmd.load) begin
                r_ptr <= (i_command == CMD_CLEAR) ? '0 : i_start_row[AW-1:0];
                r_issue_done <= 1'b0;
            end else if (i_cmd.decide) begin
                r_ptr <= r_s;
                r_issue_done <= 1'b0;
            end else if (i_cmd.clear_run) begin
                r_ptr <= r_ptr + 1'b1;
            end else if (rd_en) begin
                r_ptr <= r_ptr + 1'b1;
                r_issue_done <= (r_ptr == r_lim);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_command;
            r_bad <= in_bad;
            r_s <= i_start_row[AW-1:0];
            r_lim <= i_end_row[AW-1:0];
            r_occ <= '0;
            r_att <= '0;
            r_alive <= ALL;
            r_tmask <= '0;
        end else if (i_cmd.scan_run && r_rv) begin
            r_occ <= r_occ | rocc;
            r_att <= r_att | ratt;
            r_alive <= nalive;
            if (nalive != '0) begin
                r_tmask <= nalive;
                r_tlast <= r_drow;
            end
        end else if (i_cmd.decide) begin
            r_fail <= 1'b0;
            if (free_m != '0) begin
                r_ch <= CW'(f_lowest(MAX_CH'(free_m)));
                r_st <= ST_FREE;
            end else if (steal_m != '0) begin
                r_ch <= CW'(f_lowest(MAX_CH'(steal_m)));
                r_st <= ST_STOLEN;
            end else if (r_tmask != '0) begin
                r_ch <= CW'(f_lowest(MAX_CH'(r_tmask)));
                r_st <= ST_TRUNC;
                r_lim <= r_tlast;
            end else begin
                r_fail <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_cmd == CMD_CLEAR) begin
                r_o_ch <= '0;
                r_o_end <= '0;
                r_o_st <= ST_CLEAR;
            end else if (r_bad || r_fail) begin
                r_o_ch <= '0;
                r_o_end <= '0;
                r_o_st <= ST_DROP;
            end else begin
                r_o_ch <= ch5[CH_OUT_W-1:0];
                r_o_end <= ROW_W'(r_lim);
                r_o_st <= r_st;
            end
        end
    end

    assign o_channel = r_o_ch;
    assign o_placed_end_row = r_o_end;
    assign o_status = r_o_st;

    assign o_stat.clear_done = (r_ptr == AW'(DEPTH - 1));
    assign o_stat.scan_done = r_issue_done && !r_rv;
    assign o_stat.write_done = r_issue_done && !r_rv;
    assign o_stat.bad = r_bad;
    assign o_stat.fail = r_fail;
    assign o_stat.is_clear = (r_cmd == CMD_CLEAR);

    a_read_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rv |-> $past(rd_en))
        else $error("read data without a read");

    a_write_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.write_run && r_rv) |-> (r_drow >= r_s && r_drow <= r_lim))
        else $error("row write outside placed span");

    a_no_mixed_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear_run |-> !rd_en)
        else $error("read issued during clearing pass");

endmodule

@@ src/nca_ctrl.sv @@
// controller: sequences clearing, row scan, choice, row write and result transfer
// depends on nca_pkg
module nca_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output nca_pkg::t_nca_cmd   o_cmd,
    input  nca_pkg::t_nca_stat  i_stat
);
    import nca_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_CLEAR,
        S_DECIDE,
        S_WRITE,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ovalid;
    logic   n_ovalid;
    logic   out_free;

    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign out_free = !r_ovalid || !i_out_stall;

    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        n_ovalid = r_ovalid && i_out_stall;
        case (r_state)
            S_INIT: begin
                o_cmd.clear_run = 1'b1;
                if (i_stat.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.is_clear) begin
                    n_state = S_CLEAR;
                end else if (i_stat.bad) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.scan_run = 1'b1;
                    if (i_stat.scan_done) begin
                        n_state = S_DECIDE;
                    end
                end
            end
            S_CLEAR: begin
                o_cmd.clear_run = 1'b1;
                if (i_stat.clear_done) begin
                    n_state = S_DONE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state = S_WRITE;
            end
            S_WRITE: begin
                if (i_stat.fail) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.write_run = 1'b1;
                    if (i_stat.write_done) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_ovalid || !i_out_stall))
        else $error("result register overwritten before transfer");

    a_load_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> !o_cmd.load)
        else $error("second load without processing");

    a_out_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_DONE))
        else $error("result raised outside completion");

endmodule
